// ===== rtl/mfbr_pkg.sv =====
`default_nettype none
package mfbr_pkg;

  localparam int BUFFER_WORDS_DEF = 1024;
  localparam int MAX_WIDTH_DEF    = 32;
  localparam int QUEUE_DEPTH      = 4;
  localparam int MOD_IN_W         = 30;
  localparam int WIDTH_W          = 6;
  localparam int CFG_W            = 12;
  localparam int FUNC_W           = 3;
  localparam int INDEX_W          = 10;
  localparam int DATA_W           = 32;
  localparam int POS_W            = 12;
  localparam int IN_DATA_W        = 80;
  localparam int OUT_DATA_W       = 48;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD   = 3'd0,
    FN_WIDTH  = 3'd1,
    FN_READ   = 3'd2,
    FN_SKIP   = 3'd3,
    FN_SETPOS = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_WIDTH,
    OP_READ,
    OP_SKIP,
    OP_SETPOS
  } op_t;

  typedef enum logic [0:0] {
    CFG_ATTACHED = 1'b0,
    CFG_BASE     = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MOD,
    B_RD2,
    B_RD3,
    B_BASE
  } back_state_t;

  typedef struct packed {
    op_t                 op;
    logic [INDEX_W-1:0]  word_index;
    logic [DATA_W-1:0]   word_data;
    logic [DATA_W-1:0]   amount;
    logic [WIDTH_W-1:0]  width;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/msb_first_bit_reader.sv =====
// msb_first_bit_reader
// input stream: one transfer per operation, s_tuser selects it (load word,
// set width, read field, skip bits, set bit position, other codes do nothing)
// output stream: exactly one transfer per input transfer, in order, carrying
// the read field (zero unless a read) and the byte pointer after the operation
// config port: cfg_index 0 attaches the buffer when bit 0 is set, detaches it
// when bit 0 is clear; cfg_index 1 sets the base byte offset
// the back end takes a new operation from the queue only once the previous
// one has finished; an attached read fetches three buffer words over the
// two read ports
// buffer positions are reduced modulo the buffer size, by a mask for a
// power-of-two size and by a pipelined reciprocal multiply otherwise; load,
// skip and set position wait for the reduction, as does a base offset write
// a four-entry queue sits between the decode front and the execute back; a
// stalled receiver holds the output register, the queue fills, then s_tready
// drops
// reset: byte and bit position 0, width 1, buffer detached, base 0; buffer
// contents are undefined until loaded
`default_nettype none
module msb_first_bit_reader #(
  parameter int BUFFER_WORDS = mfbr_pkg::BUFFER_WORDS_DEF,
  parameter int MAX_WIDTH    = mfbr_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // word_index[9:0], word_data[41:10], amount[73:42], zero fill
  input  logic [mfbr_pkg::IN_DATA_W-1:0]  s_tdata,
  // func[2:0]
  input  logic [mfbr_pkg::FUNC_W-1:0]     s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // read_data[31:0], byte_position[43:32], zero fill
  output logic [mfbr_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  mfbr_pkg::cfg_idx_t              cfg_index,
  input  logic [mfbr_pkg::CFG_W-1:0]      cfg_data
);
  import mfbr_pkg::*;

  logic              q_valid;
  logic              q_pop;
  entry_t            q_entry;
  logic [DATA_W-1:0] res_data;
  logic [POS_W-1:0]  res_pos;

  mfbr_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_pop    (q_pop),
    .q_valid  (q_valid),
    .q_entry  (q_entry)
  );

  mfbr_back #(.BUFFER_WORDS(BUFFER_WORDS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (res_data),
    .out_pos   (res_pos)
  );

  assign m_tdata = {{(OUT_DATA_W - DATA_W - POS_W){1'b0}}, res_pos, res_data};

endmodule
`default_nettype wire

// ===== rtl/mfbr_ram.sv =====
`default_nettype none
module mfbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mfbr_mod.sv =====
`default_nettype none
module mfbr_mod #(
  parameter int BUFFER_WORDS = mfbr_pkg::BUFFER_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mfbr_pkg::MOD_IN_W-1:0] value,
  output logic                          rdy,
  output logic [$clog2(4*BUFFER_WORDS)-1:0] result
);
  import mfbr_pkg::*;

  localparam int C    = 4 * BUFFER_WORDS;
  localparam int BPW  = $clog2(C);
  localparam bit POW2 = (BUFFER_WORDS & (BUFFER_WORDS - 1)) == 0;

  generate
    if (POW2) begin : g_mask
      always_ff @(posedge clk) begin
        if (rst) begin
          rdy <= 1'b0;
        end else if (start) begin
          rdy <= 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          result <= value[BPW-1:0];
        end
      end
    end else begin : g_recip
      localparam int PW = 2 * MOD_IN_W;
      localparam logic [MOD_IN_W-1:0] RECIP = MOD_IN_W'((1 << MOD_IN_W) / C);
      localparam logic [MOD_IN_W-1:0] C_V   = MOD_IN_W'(C);
      localparam logic [BPW:0]        C_K   = (BPW+1)'(C);

      logic [MOD_IN_W-1:0] val_q;
      logic [MOD_IN_W-1:0] quot;
      logic [BPW:0]        part;
      logic [BPW-1:0]      rem;
      logic [2:0]          stage;
      logic [PW-1:0]       prod;
      logic [MOD_IN_W-1:0] qc;
      logic [MOD_IN_W-1:0] diff;

      // quotient estimate is at most one low, one correction step
      assign prod   = val_q * RECIP;
      assign qc     = quot * C_V;
      assign diff   = val_q - qc;
      assign result = rem;

      always_ff @(posedge clk) begin
        if (rst) begin
          stage <= '0;
          rdy   <= 1'b0;
        end else if (start) begin
          stage <= 3'b001;
          rdy   <= 1'b0;
        end else begin
          stage <= {stage[1:0], 1'b0};
          if (stage[2]) begin
            rdy <= 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          val_q <= value;
        end
        quot <= prod[PW-1:MOD_IN_W];
        part <= diff[BPW:0];
        rem  <= (part >= C_K) ? BPW'(part - C_K) : part[BPW-1:0];
      end
    end
  endgenerate

endmodule
`default_nettype wire

// ===== rtl/mfbr_front.sv =====
`default_nettype none
module mfbr_front #(
  parameter int MAX_WIDTH = mfbr_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mfbr_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [mfbr_pkg::FUNC_W-1:0]    s_tuser,
  input  logic                           q_pop,
  output logic                           q_valid,
  output mfbr_pkg::entry_t               q_entry
);
  import mfbr_pkg::*;

  localparam int QPW = $clog2(QUEUE_DEPTH);

  entry_t             mem [QUEUE_DEPTH];
  logic [QPW-1:0]     wr_ptr;
  logic [QPW-1:0]     rd_ptr;
  logic [QPW:0]       count;
  logic               push;
  entry_t             in_entry;
  logic [DATA_W-1:0]  amount;

  assign amount = s_tdata[73:42];

  always_comb begin
    in_entry.word_index = s_tdata[9:0];
    in_entry.word_data  = s_tdata[41:10];
    in_entry.amount     = amount;
    if (amount == '0) begin
      in_entry.width = WIDTH_W'(1);
    end else if (amount > DATA_W'(MAX_WIDTH)) begin
      in_entry.width = WIDTH_W'(MAX_WIDTH);
    end else begin
      in_entry.width = amount[WIDTH_W-1:0];
    end
    case (func_t'(s_tuser))
      FN_LOAD:   in_entry.op = OP_LOAD;
      FN_WIDTH:  in_entry.op = OP_WIDTH;
      FN_READ:   in_entry.op = OP_READ;
      FN_SKIP:   in_entry.op = OP_SKIP;
      FN_SETPOS: in_entry.op = OP_SETPOS;
      default:   in_entry.op = OP_NOP;
    endcase
  end

  assign s_tready = count != (QPW+1)'(QUEUE_DEPTH);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = count != '0;
  assign q_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPW+1)'(push) - (QPW+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_entry;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== rtl/mfbr_back.sv =====
`default_nettype none
module mfbr_back #(
  parameter int BUFFER_WORDS = mfbr_pkg::BUFFER_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  mfbr_pkg::cfg_idx_t           cfg_index,
  input  logic [mfbr_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         q_valid,
  input  mfbr_pkg::entry_t             q_entry,
  output logic                         q_pop,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [mfbr_pkg::DATA_W-1:0]  out_data,
  output logic [mfbr_pkg::POS_W-1:0]   out_pos
);
  import mfbr_pkg::*;

  localparam int C   = 4 * BUFFER_WORDS;
  localparam int BPW = $clog2(C);
  localparam int AW  = $clog2(BUFFER_WORDS);
  localparam logic [BPW:0]  C_K    = (BPW+1)'(C);
  localparam logic [AW-1:0] W_LAST = AW'(BUFFER_WORDS - 1);

  back_state_t         state, state_next;
  entry_t              cur, cur_next;
  logic [2:0]          cbit, cbit_next;
  logic [BPW-1:0]      bp, bp_next;
  logic [BPW-1:0]      base_mod, base_next;
  logic [2:0]          bitp, bit_next;
  logic [WIDTH_W-1:0]  rw, rw_next;
  logic                attached, att_next;
  logic [AW-1:0]       sw2, sw2_next;
  logic [DATA_W-1:0]   w0, w0_next, w1, w1_next;
  logic                res_valid, res_valid_next;
  logic [DATA_W-1:0]   res_data, res_data_next;
  logic [POS_W-1:0]    res_pos, res_pos_next;

  logic                res_free;
  logic [BPW:0]        g_sum, g_wrap;
  logic [AW-1:0]       sw, sw1, sw2_c;
  logic                mod_start, mod_rdy;
  logic [MOD_IN_W-1:0] mod_value;
  logic [BPW-1:0]      mod_res;
  logic                ram_we, re_a, re_b;
  logic [AW-1:0]       raddr_a, raddr_b;
  logic [DATA_W-1:0]   rdata_a, rdata_b;
  logic [32:0]         sk_total;
  logic [BPW:0]        sk_sum, adv_sum;
  logic [BPW-1:0]      sk_bp, adv_bp;
  logic [5:0]          adv_total;
  logic [5:0]          shamt;
  logic [39:0]         acc, mask, field;
  logic [95:0]         win;
  logic                fin;
  logic [DATA_W-1:0]   fin_data;
  logic [BPW+POS_W-1:0] pos_ext;

  mfbr_mod #(.BUFFER_WORDS(BUFFER_WORDS)) u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (mod_start),
    .value  (mod_value),
    .rdy    (mod_rdy),
    .result (mod_res)
  );

  mfbr_ram #(.WIDTH(DATA_W), .DEPTH(BUFFER_WORDS)) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (mod_res[BPW-1:2]),
    .wdata   (cur.word_data),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .re_b    (re_b),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign res_free = !res_valid || out_ready;

  // first word of the read window, words wrap at the buffer end
  assign g_sum  = {1'b0, base_mod} + {1'b0, bp[BPW-1:2], 2'b00};
  assign g_wrap = (g_sum >= C_K) ? g_sum - C_K : g_sum;
  assign sw     = g_wrap[BPW-1:2];
  assign sw1    = (sw == W_LAST) ? '0 : sw + 1'b1;
  assign sw2_c  = (sw1 == W_LAST) ? '0 : sw1 + 1'b1;

  assign sk_total = {1'b0, q_entry.amount} + 33'(bitp);
  assign sk_sum   = {1'b0, bp} + {1'b0, mod_res};
  assign sk_bp    = (sk_sum >= C_K) ? BPW'(sk_sum - C_K) : sk_sum[BPW-1:0];

  assign adv_total = rw + 6'(bitp);
  assign adv_sum   = {1'b0, bp} + (BPW+1)'(adv_total[5:3]);
  assign adv_bp    = (adv_sum >= C_K) ? BPW'(adv_sum - C_K) : adv_sum[BPW-1:0];

  assign win = {rdata_a, w1, w0};

  always_comb begin : field_calc
    logic [2:0] ri;
    logic [3:0] p;
    acc = '0;
    for (int i = 0; i < 5; i++) begin
      ri  = 3'(bp[1:0]) + 3'(i);
      p   = 4'(base_mod[1:0]) + 4'(ri ^ 3'd3);
      acc = {acc[31:0], win[{p, 3'b000} +: 8]};
    end
    shamt = 6'd40 - 6'(bitp) - rw;
    mask  = (40'd1 << rw) - 40'd1;
    field = (acc >> shamt) & mask;
  end

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    cbit_next      = cbit;
    bp_next        = bp;
    bit_next       = bitp;
    rw_next        = rw;
    base_next      = base_mod;
    att_next       = attached;
    sw2_next       = sw2;
    w0_next        = w0;
    w1_next        = w1;
    res_valid_next = res_valid && !out_ready;
    res_data_next  = res_data;
    res_pos_next   = res_pos;
    q_pop          = 1'b0;
    mod_start      = 1'b0;
    mod_value      = '0;
    ram_we         = 1'b0;
    re_a           = 1'b0;
    re_b           = 1'b0;
    raddr_a        = sw;
    raddr_b        = sw1;
    fin            = 1'b0;
    fin_data       = '0;

    case (state)
      B_IDLE: begin
        if (q_valid && res_free && !cfg_we) begin
          q_pop    = 1'b1;
          cur_next = q_entry;
          case (q_entry.op)
            OP_LOAD: begin
              mod_start  = 1'b1;
              mod_value  = MOD_IN_W'({q_entry.word_index, 2'b00});
              state_next = B_MOD;
            end
            OP_SKIP: begin
              mod_start  = 1'b1;
              mod_value  = sk_total[32:3];
              cbit_next  = sk_total[2:0];
              state_next = B_MOD;
            end
            OP_SETPOS: begin
              mod_start  = 1'b1;
              mod_value  = {1'b0, q_entry.amount[31:3]};
              state_next = B_MOD;
            end
            OP_WIDTH: begin
              rw_next = q_entry.width;
              fin     = 1'b1;
            end
            OP_READ: begin
              if (attached) begin
                re_a       = 1'b1;
                re_b       = 1'b1;
                sw2_next   = sw2_c;
                state_next = B_RD2;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      B_MOD: begin
        if (mod_rdy && res_free) begin
          case (cur.op)
            OP_LOAD: begin
              ram_we = 1'b1;
            end
            OP_SKIP: begin
              bp_next  = sk_bp;
              bit_next = cbit;
            end
            OP_SETPOS: begin
              bp_next  = mod_res;
              bit_next = cur.amount[2:0];
            end
            default: begin
            end
          endcase
          fin        = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_RD2: begin
        w0_next    = rdata_a;
        w1_next    = rdata_b;
        re_a       = 1'b1;
        raddr_a    = sw2;
        state_next = B_RD3;
      end
      B_RD3: begin
        if (res_free) begin
          fin_data   = field[DATA_W-1:0];
          bp_next    = adv_bp;
          bit_next   = adv_total[2:0];
          fin        = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_BASE: begin
        if (mod_rdy) begin
          base_next  = mod_res;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase

    pos_ext = {{POS_W{1'b0}}, bp_next};
    if (fin) begin
      res_valid_next = 1'b1;
      res_data_next  = fin_data;
      res_pos_next   = pos_ext[POS_W-1:0];
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACHED: begin
          att_next = cfg_data[0];
        end
        CFG_BASE: begin
          mod_start  = 1'b1;
          mod_value  = MOD_IN_W'(cfg_data);
          state_next = B_BASE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bp        <= '0;
      bitp      <= '0;
      rw        <= WIDTH_W'(1);
      attached  <= 1'b0;
      base_mod  <= '0;
      res_valid <= 1'b0;
    end else begin
      bp        <= bp_next;
      bitp      <= bit_next;
      rw        <= rw_next;
      attached  <= att_next;
      base_mod  <= base_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    cbit     <= cbit_next;
    sw2      <= sw2_next;
    w0       <= w0_next;
    w1       <= w1_next;
    res_data <= res_data_next;
    res_pos  <= res_pos_next;
  end

  assign out_valid = res_valid;
  assign out_data  = res_data;
  assign out_pos   = res_pos;

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == B_IDLE) && res_free)
    else $error("queue popped while back end busy or result blocked");

  a_rd_order: assert property (@(posedge clk) disable iff (rst)
    (state == B_RD3) |-> ($past(state) == B_RD2) || ($past(state) == B_RD3))
    else $error("read finish without word fetch");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> ({1'b0, bp} < C_K) && ({1'b0, base_mod} < C_K))
    else $error("byte pointer or base beyond buffer");

endmodule
`default_nettype wire

// ===== sim/msb_first_bit_reader_test.sv =====
`timescale 1ns / 1ps
module msb_first_bit_reader_test;
  import mfbr_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = 3'd7;
  localparam int NUM_WORDS     = 1024;
  localparam int WATCHDOG_MAX  = 5000;
  localparam int PHASE_OPS     = 345;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [POS_W-1:0]  byte_position;
  } field_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_ATTACHED;
  logic [CFG_W-1:0] cfg_data = '0;

  // reader model state
  bit [DATA_W-1:0] model_words [NUM_WORDS];
  bit word_loaded [NUM_WORDS];
  logic [POS_W-1:0] model_byte_ptr = '0;
  logic [2:0] model_bit_ptr = '0;
  logic [WIDTH_W-1:0] model_width = 6'd1;
  logic model_attached = 1'b0;
  logic [CFG_W-1:0] model_base = '0;

  field_result_t expected_fields [$];
  field_result_t oldest_field;

  int errors = 0;
  int ops_sent = 0;
  int reads_sent = 0;
  int results_checked = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_request = 0;
  int idle_cycles = 0;

  msb_first_bit_reader DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] stream_byte(logic [POS_W-1:0] k);
    logic [POS_W-1:0] addr;
    logic [DATA_W-1:0] w;
    addr = model_base + (k ^ 12'd3);
    w = model_words[addr[11:2]];
    return 8'(w >> (addr[1:0] * 8));
  endfunction

  task automatic advance_bits(longint unsigned bits);
    longint unsigned total;
    total = bits + model_bit_ptr;
    model_byte_ptr = model_byte_ptr + 12'(total >> 3);
    model_bit_ptr = total[2:0];
  endtask

  task automatic step_reader_model(logic [FUNC_W-1:0] code, logic [INDEX_W-1:0] idx,
                                   logic [DATA_W-1:0] data, logic [DATA_W-1:0] amt,
                                   output field_result_t res);
    logic [63:0] acc;
    int shift;
    res.read_data = '0;
    case (code)
      FN_LOAD: begin
        model_words[idx] = data;
        word_loaded[idx] = 1'b1;
      end
      FN_WIDTH: begin
        if (amt == 0) model_width = 6'd1;
        else if (amt > MAX_WIDTH_DEF) model_width = 6'(MAX_WIDTH_DEF);
        else model_width = amt[WIDTH_W-1:0];
      end
      FN_READ: begin
        reads_sent++;
        if (model_attached) begin
          acc = '0;
          for (int i = 0; i < 5; i++) begin
            acc = {acc[55:0], stream_byte(model_byte_ptr + 12'(i))};
          end
          shift = 40 - model_bit_ptr - model_width;
          res.read_data = 32'((acc >> shift) & ((64'd1 << model_width) - 64'd1));
          advance_bits(model_width);
        end
      end
      FN_SKIP: advance_bits(amt);
      FN_SETPOS: begin
        model_byte_ptr = amt[14:3];
        model_bit_ptr = amt[2:0];
      end
      default: ;
    endcase
    res.byte_position = model_byte_ptr;
  endtask

  task automatic send_op(logic [FUNC_W-1:0] code, logic [INDEX_W-1:0] idx,
                         logic [DATA_W-1:0] data, logic [DATA_W-1:0] amt);
    int gap;
    bit took;
    field_result_t res;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= code;
    s_tdata <= {6'b0, amt, data, idx};
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
    step_reader_model(code, idx, data, amt, res);
    expected_fields.push_back(res);
    ops_sent++;
  endtask

  // a read must only touch loaded words
  task automatic load_missing_words();
    logic [POS_W-1:0] k;
    logic [POS_W-1:0] addr;
    for (int i = 0; i < 5; i++) begin
      k = model_byte_ptr + 12'(i);
      addr = model_base + (k ^ 12'd3);
      if (!word_loaded[addr[11:2]]) send_op(FN_LOAD, addr[11:2], $urandom, $urandom);
    end
  endtask

  task automatic read_field();
    load_missing_words();
    send_op(FN_READ, 10'($urandom), $urandom, $urandom);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ATTACHED) model_attached = value[0];
    else model_base = value;
  endtask

  task automatic random_op();
    int unsigned pick;
    logic [DATA_W-1:0] amt;
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      send_op(FN_LOAD, 10'($urandom), $urandom, $urandom);
    end else if (pick < 28) begin
      amt = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 34);
      send_op(FN_WIDTH, 10'($urandom), $urandom, amt);
    end else if (pick < 68) begin
      read_field();
    end else if (pick < 83) begin
      case ($urandom_range(0, 9))
        0: amt = $urandom;
        1, 2: amt = $urandom_range(0, 50000);
        default: amt = $urandom_range(0, 70);
      endcase
      send_op(FN_SKIP, 10'($urandom), $urandom, amt);
    end else if (pick < 95) begin
      amt = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(32700, 32767);
      send_op(FN_SETPOS, 10'($urandom), $urandom, amt);
    end else begin
      send_op(3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST)), 10'($urandom), $urandom,
              $urandom);
    end
  endtask

  task automatic test_reset_defaults();
    send_op(FN_SPARE_FIRST, '0, '0, '0);
    read_field();
    write_reg(CFG_ATTACHED, 12'd1);
    write_reg(CFG_BASE, 12'd0);
    read_field();
  endtask

  task automatic test_directed_ops();
    send_op(FN_LOAD, 10'd0, 32'hFFFF_FFFF, '0);
    send_op(FN_LOAD, 10'd1, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(FN_LOAD, 10'd1023, 32'hA5C3_0F81, '0);
    send_op(FN_LOAD, 10'd2, 32'h1234_5678, '0);
    send_op(FN_WIDTH, '0, '0, 32'd0);
    read_field();
    send_op(FN_WIDTH, '0, '0, 32'd32);
    read_field();
    send_op(FN_WIDTH, '0, '0, 32'd33);
    send_op(FN_WIDTH, '0, '0, 32'hFFFF_FFFF);
    send_op(FN_WIDTH, '0, '0, 32'd7);
    read_field();
    send_op(FN_SKIP, '0, '0, 32'd0);
    send_op(FN_SKIP, '0, '0, 32'hFFFF_FFFF);
    send_op(FN_SETPOS, '0, '0, 32'hFFFF_FFFF);
    send_op(FN_WIDTH, '0, '0, 32'd32);
    read_field();
    for (int f = FN_SPARE_FIRST; f <= FN_SPARE_LAST; f++) begin
      send_op(f[FUNC_W-1:0], '1, '1, '1);
    end
    send_op(FN_SETPOS, '0, '0, 32'd0);
    write_reg(CFG_BASE, 12'd4095);
    read_field();
    send_op(FN_SETPOS, '0, '0, 32'd32700);
    read_field();
    write_reg(CFG_ATTACHED, 12'd0);
    read_field();
  endtask

  task automatic test_random_phase(int send_pct, int stall_pct, logic attached,
                                   logic [CFG_W-1:0] base);
    int start;
    write_reg(CFG_ATTACHED, {11'b0, attached});
    write_reg(CFG_BASE, base);
    sender_idle_pct = send_pct;
    receiver_stall_pct = stall_pct;
    start = ops_sent;
    while (ops_sent - start < PHASE_OPS) random_op();
  endtask

  task automatic test_output_holdoff();
    write_reg(CFG_ATTACHED, 12'd1);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_request = HOLD_CYCLES;
    repeat (40) random_op();
  endtask

  // receiver
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold = hold_request;
        hold_request = 0;
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_fields.size() == 0) begin
        $error("result transfer with nothing pending: tdata %h", m_tdata);
        errors++;
      end else begin
        oldest_field = expected_fields.pop_front();
        if (m_tdata[31:0] !== oldest_field.read_data) begin
          $error("read_data expected %h actual %h", oldest_field.read_data, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[43:32] !== oldest_field.byte_position) begin
          $error("byte_position expected %h actual %h", oldest_field.byte_position,
                 m_tdata[43:32]);
          errors++;
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_ops();
    test_random_phase(0, 0, 1'b1, 12'd0);
    test_random_phase(52, 0, 1'b1, 12'd4095);
    test_random_phase(0, 52, 1'b0, 12'($urandom));
    test_random_phase(33, 33, 1'b1, 12'($urandom));
    test_output_holdoff();
    drain_results();
    repeat (50) @(posedge clk);
    $display("%0d operations sent (%0d reads), %0d results compared", ops_sent, reads_sent,
             results_checked);
    $display("covered idle and stall mixes, a long output hold-off, detached reads, wraps");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mfbr_pkg.sv
rtl/mfbr_ram.sv
rtl/mfbr_mod.sv
rtl/mfbr_front.sv
rtl/mfbr_back.sv
rtl/msb_first_bit_reader.sv
sim/msb_first_bit_reader_test.sv
